@@ rtl/core/sns_pkg.sv @@
// Shared types and constants for the step sequencer note scheduler.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sns_pkg;

  localparam int unsigned NumInstrumentsDef = 4;
  localparam int unsigned MaxStepsDef       = 2;
  localparam int unsigned PatternLength     = 16;
  localparam int unsigned MaxBlockSamples   = 4096;

  localparam int unsigned StartW   = 40;
  localparam int unsigned SampleW  = 13;
  localparam int unsigned OffsetW  = 12;
  localparam int unsigned ChanW    = 4;
  localparam int unsigned NoteW    = 7;
  localparam int unsigned VelW     = 7;
  localparam int unsigned FracW    = 16;
  localparam int unsigned SpsW     = 32;
  localparam int unsigned NoteLenW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 32;

  localparam logic [ChanW-1:0] DrumChannel = 4'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLES_PER_STEP  = 3'd0,
    CFG_NOTE_LENGTH       = 3'd1,
    CFG_PATTERN_BITS      = 3'd2,
    CFG_NOTE_NUMBERS      = 3'd3,
    CFG_VELOCITIES        = 3'd4,
    CFG_DRUM_MASK         = 3'd5,
    CFG_INSTRUMENT_ENABLE = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [SpsW-1:0]     samples_per_step;
    logic [NoteLenW-1:0] note_length;
    logic [63:0]         pattern_bits;
    logic [27:0]         note_numbers;
    logic [27:0]         velocities;
    logic [3:0]          drum_mask;
    logic [3:0]          instrument_enable;
  } cfg_t;

  localparam logic [SpsW-1:0]     RstSamplesPerStep = 32'd393216000;
  localparam logic [NoteLenW-1:0] RstNoteLength     = 16'd2700;
  localparam logic [27:0]         RstNoteNumbers    = 28'd126819900;
  localparam logic [27:0]         RstVelocities     = 28'd211366500;

  typedef struct packed {
    logic               last;
    logic               is_note_on;
    logic [VelW-1:0]    velocity;
    logic [NoteW-1:0]   note_number;
    logic [ChanW-1:0]   channel;
    logic [OffsetW-1:0] sample_offset;
  } event_t;

endpackage

`default_nettype wire

@@ rtl/core/step_sequencer_note_scheduler.sv @@
// Channel    | Dir | Payload
// s_axis     | in  | tdata: block_start_step[39:0], block_samples[52:40]
// m_axis     | out | tdata: offset, channel, note, velocity; tuser: note-on; tlast
// cfg        | in  | cfg_we_i / cfg_idx_i / cfg_data_i, one register per write
//
// One block runs through the accept in idle, then for each visited step the shared
// multiplier and the compare, then for each instrument a pattern check and, on a
// hit, a push of the held note-off (when one is pending) before the note-on, and
// a closing state that pushes the last held note-off. s_axis_tready is high only
// while idle. Reset is asynchronous, active low. A stalled m_axis holds the
// sequencer at its next event push.
// Top level; depends on sns_pkg, sns_cfg, sns_mul, sns_out and sns_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module step_sequencer_note_scheduler import sns_pkg::*; #(
  parameter int unsigned NUM_INSTRUMENTS     = NumInstrumentsDef,
  parameter int unsigned MAX_STEPS_PER_BLOCK = MaxStepsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [39:0] block_start_step, [52:40] block_samples, [55:53] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [11:0] sample_offset, [15:12] channel, [22:16] note_number,
  // [29:23] velocity, [31:30] zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  // [0] is_note_on
  output logic                     m_axis_tuser,
  output logic                     m_axis_tlast,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned DW = FracW + ((MAX_STEPS_PER_BLOCK > 1) ?
                                        $clog2(MAX_STEPS_PER_BLOCK) : 0);

  cfg_t               cfg;
  logic               mul_start;
  logic [DW-1:0]      mul_a;
  logic [DW+SpsW-1:0] mul_prod;
  logic               push_vld;
  logic               push_rdy;
  event_t             push_ev;

  sns_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sns_mul #(
    .AW (DW)
  ) u_mul (
    .clk_i   (clk_i),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (cfg.samples_per_step),
    .prod_o  (mul_prod)
  );

  sns_ctrl #(
    .NUM_INSTRUMENTS     (NUM_INSTRUMENTS),
    .MAX_STEPS_PER_BLOCK (MAX_STEPS_PER_BLOCK),
    .DW                  (DW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_vld_i    (s_axis_tvalid),
    .in_rdy_o    (s_axis_tready),
    .start_i     (s_axis_tdata[StartW-1:0]),
    .samples_i   (s_axis_tdata[StartW +: SampleW]),
    .mul_start_o (mul_start),
    .mul_a_o     (mul_a),
    .mul_prod_i  (mul_prod),
    .push_vld_o  (push_vld),
    .push_ev_o   (push_ev),
    .push_rdy_i  (push_rdy)
  );

  sns_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_vld_i    (push_vld),
    .push_ev_i     (push_ev),
    .push_rdy_o    (push_rdy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/core/sns_cfg.sv @@
// Configuration register file of the note scheduler.
// Depends on sns_pkg for the register index codes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module sns_cfg import sns_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SAMPLES_PER_STEP:  cfg_d.samples_per_step  = cfg_data_i[SpsW-1:0];
        CFG_NOTE_LENGTH:       cfg_d.note_length       = cfg_data_i[NoteLenW-1:0];
        CFG_PATTERN_BITS:      cfg_d.pattern_bits      = cfg_data_i[63:0];
        CFG_NOTE_NUMBERS:      cfg_d.note_numbers      = cfg_data_i[27:0];
        CFG_VELOCITIES:        cfg_d.velocities        = cfg_data_i[27:0];
        CFG_DRUM_MASK:         cfg_d.drum_mask         = cfg_data_i[3:0];
        CFG_INSTRUMENT_ENABLE: cfg_d.instrument_enable = cfg_data_i[3:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.samples_per_step  <= RstSamplesPerStep;
      cfg_q.note_length       <= RstNoteLength;
      cfg_q.pattern_bits      <= '0;
      cfg_q.note_numbers      <= RstNoteNumbers;
      cfg_q.velocities        <= RstVelocities;
      cfg_q.drum_mask         <= '0;
      cfg_q.instrument_enable <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/sns_mul.sv @@
// Shared offset multiplier: step distance (Q.16) times samples per step (Q16.16).
// Product is registered; one product per visited step. Depends on sns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sns_mul import sns_pkg::*; #(
  parameter int unsigned AW = 17
) (
  input  wire logic               clk_i,
  input  wire logic               start_i,
  input  wire logic [AW-1:0]      a_i,
  input  wire logic [SpsW-1:0]    b_i,
  output logic      [AW+SpsW-1:0] prod_o
);

  logic [AW+SpsW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= (AW+SpsW)'(a_i) * (AW+SpsW)'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

@@ rtl/core/sns_out.sv @@
// Output register stage: holds one event until the downstream transfer.
// Depends on sns_pkg for event_t.
`timescale 1ns / 1ps
`default_nettype none

module sns_out import sns_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_vld_i,
  input  event_t                   push_ev_i,
  output logic                     push_rdy_o,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tuser,
  output logic                     m_axis_tlast
);

  logic   vld_q;
  event_t ev_q;

  assign push_rdy_o = !vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (push_rdy_o) begin
      vld_q <= push_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_rdy_o && push_vld_i) begin
      ev_q <= push_ev_i;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {2'b00, ev_q.velocity, ev_q.note_number, ev_q.channel,
                          ev_q.sample_offset};
  assign m_axis_tuser  = ev_q.is_note_on;
  assign m_axis_tlast  = ev_q.last;

endmodule

`default_nettype wire

@@ rtl/core/sns_ctrl.sv @@
// Sequencer of the note scheduler: walks the steps of one block, drives the
// shared multiplier and emits events. Depends on sns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sns_ctrl import sns_pkg::*; #(
  parameter int unsigned NUM_INSTRUMENTS     = NumInstrumentsDef,
  parameter int unsigned MAX_STEPS_PER_BLOCK = MaxStepsDef,
  parameter int unsigned DW = FracW + ((MAX_STEPS_PER_BLOCK > 1) ?
                                       $clog2(MAX_STEPS_PER_BLOCK) : 0)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  cfg_t                    cfg_i,
  input  wire logic               in_vld_i,
  output logic                    in_rdy_o,
  input  wire logic [StartW-1:0]  start_i,
  input  wire logic [SampleW-1:0] samples_i,
  output logic                    mul_start_o,
  output logic      [DW-1:0]      mul_a_o,
  input  wire logic [DW+SpsW-1:0] mul_prod_i,
  output logic                    push_vld_o,
  output event_t                  push_ev_o,
  input  wire logic               push_rdy_i
);

  localparam int unsigned IW  = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
  localparam int unsigned CNW = $clog2(MAX_STEPS_PER_BLOCK + 1);
  localparam int unsigned SW  = $clog2(PatternLength);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_TEST  = 7'b0000100,
    ST_INSTR = 7'b0001000,
    ST_FLUSH = 7'b0010000,
    ST_ON    = 7'b0100000,
    ST_END   = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [DW-1:0]      diff_q, diff_d;
  logic [SW-1:0]      sidx_q, sidx_d;
  logic [CNW-1:0]     cnt_q, cnt_d;
  logic [IW-1:0]      instr_q, instr_d;
  logic [SampleW-1:0] n_q, n_d;
  logic [OffsetW-1:0] on_q, on_d;
  logic [OffsetW-1:0] off_q, off_d;
  logic               pend_q, pend_d;
  event_t             pend_ev_q, pend_ev_d;

  logic [SampleW-1:0]  n_sat;
  logic [19:0]         start_up;
  logic [FracW-1:0]    diff_first;
  logic [DW-1:0]       prod_hi;
  logic [OffsetW-1:0]  hi;
  logic [NoteLenW:0]   off_sum;
  logic                hit;
  logic [4:0]          fbase;
  logic [NoteW-1:0]    cur_note;
  logic [VelW-1:0]     cur_vel;
  logic [ChanW-1:0]    cur_chan;
  logic                last_instr;
  logic [CNW-1:0]      cnt_inc;

  assign n_sat    = (samples_i > SampleW'(MaxBlockSamples)) ? SampleW'(MaxBlockSamples)
                                                            : samples_i;
  // first whole step at or after the start: round the Q.16 position up
  assign start_up   = start_i[19:0] + 20'h0FFFF;
  // distance to that step stays within one step, so it wraps at the fraction width
  assign diff_first = FracW'(0) - start_i[FracW-1:0];
  assign prod_hi    = mul_prod_i[DW+SpsW-1:SpsW];
  assign hi         = OffsetW'(n_q - SampleW'(1));
  assign off_sum    = (NoteLenW+1)'(on_q) + (NoteLenW+1)'(cfg_i.note_length);

  assign hit        = cfg_i.instrument_enable[instr_q] &&
                      cfg_i.pattern_bits[{instr_q, sidx_q}];
  assign fbase      = 5'(instr_q) * 5'd7;
  assign cur_note   = cfg_i.note_numbers[fbase +: NoteW];
  assign cur_vel    = (cfg_i.velocities[fbase +: VelW] == '0) ? VelW'(1)
                                                              : cfg_i.velocities[fbase +: VelW];
  assign cur_chan   = cfg_i.drum_mask[instr_q] ? DrumChannel : ChanW'(instr_q) + ChanW'(1);
  assign last_instr = (instr_q == IW'(NUM_INSTRUMENTS - 1));
  assign cnt_inc    = cnt_q + CNW'(1);

  assign in_rdy_o    = (state_q == ST_IDLE);
  assign mul_start_o = (state_q == ST_MUL);
  assign mul_a_o     = diff_q;

  always_comb begin
    state_d   = state_q;
    diff_d    = diff_q;
    sidx_d    = sidx_q;
    cnt_d     = cnt_q;
    instr_d   = instr_q;
    n_d       = n_q;
    on_d      = on_q;
    off_d     = off_q;
    pend_d    = pend_q;
    pend_ev_d = pend_ev_q;
    push_vld_o = 1'b0;
    push_ev_o  = pend_ev_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_vld_i) begin
          n_d    = n_sat;
          diff_d = DW'(diff_first);
          sidx_d = start_up[19:16];
          cnt_d  = '0;
          state_d = (n_sat == '0) ? ST_IDLE : ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_TEST;
      end
      ST_TEST: begin
        if (prod_hi >= DW'(n_q)) begin
          state_d = ST_END;
        end else begin
          // the test bounds the floored product below n, so it fits the offset
          on_d    = mul_prod_i[SpsW +: OffsetW];
          instr_d = '0;
          state_d = ST_INSTR;
        end
      end
      ST_INSTR: begin
        // note-off clamp is computed here from the registered on position
        off_d = (off_sum > (NoteLenW+1)'(hi)) ? hi : OffsetW'(off_sum);
        if (hit) begin
          state_d = pend_q ? ST_FLUSH : ST_ON;
        end else if (!last_instr) begin
          instr_d = instr_q + IW'(1);
        end else begin
          cnt_d   = cnt_inc;
          diff_d  = diff_q + DW'(1 << FracW);
          sidx_d  = sidx_q + SW'(1);
          state_d = (cnt_inc == CNW'(MAX_STEPS_PER_BLOCK)) ? ST_END : ST_MUL;
        end
      end
      ST_FLUSH: begin
        push_vld_o = 1'b1;
        push_ev_o.last = 1'b0;
        if (push_rdy_i) begin
          pend_d  = 1'b0;
          state_d = ST_ON;
        end
      end
      ST_ON: begin
        push_vld_o = 1'b1;
        push_ev_o.sample_offset = on_q;
        push_ev_o.channel       = cur_chan;
        push_ev_o.note_number   = cur_note;
        push_ev_o.velocity      = cur_vel;
        push_ev_o.is_note_on    = 1'b1;
        push_ev_o.last          = 1'b0;
        if (push_rdy_i) begin
          pend_d = 1'b1;
          pend_ev_d.sample_offset = off_q;
          pend_ev_d.channel       = cur_chan;
          pend_ev_d.note_number   = cur_note;
          pend_ev_d.velocity      = '0;
          pend_ev_d.is_note_on    = 1'b0;
          pend_ev_d.last          = 1'b0;
          if (!last_instr) begin
            instr_d = instr_q + IW'(1);
            state_d = ST_INSTR;
          end else begin
            cnt_d   = cnt_inc;
            diff_d  = diff_q + DW'(1 << FracW);
            sidx_d  = sidx_q + SW'(1);
            state_d = (cnt_inc == CNW'(MAX_STEPS_PER_BLOCK)) ? ST_END : ST_MUL;
          end
        end
      end
      ST_END: begin
        // the held note-off is the final event of the block
        push_vld_o     = pend_q;
        push_ev_o.last = 1'b1;
        if (!pend_q || push_rdy_i) begin
          pend_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      instr_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      instr_q <= instr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q    <= diff_d;
    sidx_q    <= sidx_d;
    n_q       <= n_d;
    on_q      <= on_d;
    off_q     <= off_d;
    pend_ev_q <= pend_ev_d;
  end

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_q)
    else $error("held note-off left over while idle");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNW'(MAX_STEPS_PER_BLOCK))
    else $error("step count past the per-block limit");

  a_last_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_vld_o && push_ev_o.last |-> state_q == ST_END)
    else $error("last event pushed before the block ended");

  a_on_follows_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH && push_rdy_i |=> state_q == ST_ON)
    else $error("flushed note-off not followed by its note-on");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for step_sequencer_note_scheduler: drives audio blocks and
// register settings, predicts the note-on/note-off stream and checks every m_axis transfer.
// Depends on sns_pkg and the step_sequencer_note_scheduler top level.
`timescale 1ns / 1ps

module tb_top;
  import sns_pkg::*;

  localparam int unsigned SettleCycles = 64;    // idle padding after the queues drain
  localparam int unsigned QuietLimit   = 4000;  // cycles without any transfer
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PhaseItems   = 10;
  localparam logic [CfgIdxW-1:0] CfgIdxUnmapped = 3'd7;

  // idle percentages per mode: sender, receiver
  localparam int unsigned TxIdle [3] = '{23, 61, 0};
  localparam int unsigned RxIdle [3] = '{61, 23, 0};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic [InDataW-1:0] blocks_pending [$];
  event_t             events_due [$];
  cfg_t               regs;
  logic               block_taken = 1'b0;
  int unsigned        tx_idle_pct = TxIdle[0];
  int unsigned        rx_idle_pct = RxIdle[0];
  int unsigned        mismatches = 0;
  int unsigned        quiet_cycles = 0;

  step_sequencer_note_scheduler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Expected events of one audio block, appended to events_due in output order.
  task automatic schedule_block(input logic [StartW-1:0] start, input logic [SampleW-1:0] samples);
    logic [63:0] ustart, rounded, diff, limit, hi, prod, on_pos, off_pos;
    logic [3:0]  step_idx;
    logic [6:0]  vel;
    logic [3:0]  chan;
    event_t      ev, held;
    bit          have_held;
    int unsigned n;
    have_held = 1'b0;
    n = (samples > MaxBlockSamples) ? MaxBlockSamples : samples;
    if (n == 0) return;
    ustart   = {{24{start[StartW-1]}}, start};
    diff     = (64'd0 - ustart) & 64'hFFFF;
    rounded  = ustart + 64'hFFFF;
    step_idx = rounded[19:16];
    limit    = 64'(n) << 32;
    hi       = 64'(n) - 64'd1;
    for (int s = 0; s < MaxStepsDef; s++) begin
      prod = diff * {32'd0, regs.samples_per_step};
      if (prod >= limit) break;
      on_pos = prod >> 32;
      if (on_pos > hi) on_pos = hi;
      off_pos = on_pos + 64'(regs.note_length);
      if (off_pos > hi) off_pos = hi;
      for (int i = 0; i < NumInstrumentsDef; i++) begin
        if (!regs.instrument_enable[i]) continue;
        if (!regs.pattern_bits[16*i + step_idx]) continue;
        vel  = regs.velocities[7*i +: 7];
        if (vel == 7'd0) vel = 7'd1;
        chan = regs.drum_mask[i] ? DrumChannel : 4'(i + 1);
        for (int k = 0; k < 2; k++) begin
          if (have_held) events_due.push_back(held);
          ev.last          = 1'b0;
          ev.is_note_on    = (k == 0);
          ev.velocity      = (k == 0) ? vel : 7'd0;
          ev.note_number   = regs.note_numbers[7*i +: 7];
          ev.channel       = chan;
          ev.sample_offset = (k == 0) ? on_pos[OffsetW-1:0] : off_pos[OffsetW-1:0];
          held      = ev;
          have_held = 1'b1;
        end
      end
      diff     = diff + 64'd65536;
      step_idx = step_idx + 4'd1;
    end
    if (have_held) begin
      held.last = 1'b1;
      events_due.push_back(held);
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: samples both handshakes at the rising edge, runs the watchdog.
  always @(posedge clk_i) begin : monitor
    event_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        block_taken = 1'b1;
        schedule_block(s_axis_tdata[StartW-1:0], s_axis_tdata[StartW +: SampleW]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (events_due.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual tdata %h tuser %b tlast %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          want = events_due.pop_front();
          check_field("sample_offset", 32'(want.sample_offset), 32'(m_axis_tdata[11:0]));
          check_field("channel", 32'(want.channel), 32'(m_axis_tdata[15:12]));
          check_field("note_number", 32'(want.note_number), 32'(m_axis_tdata[22:16]));
          check_field("velocity", 32'(want.velocity), 32'(m_axis_tdata[29:23]));
          check_field("is_note_on", 32'(want.is_note_on), 32'(m_axis_tuser));
          check_field("last_event", 32'(want.last), 32'(m_axis_tlast));
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: watchdog expired, %0d events outstanding", $time, events_due.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Driver: inputs change on the falling edge; valid holds until the transfer.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || block_taken) begin
      block_taken = 1'b0;
      if (blocks_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_axis_tdata  <= blocks_pending.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_SAMPLES_PER_STEP:  regs.samples_per_step  = value[SpsW-1:0];
      CFG_NOTE_LENGTH:       regs.note_length       = value[NoteLenW-1:0];
      CFG_PATTERN_BITS:      regs.pattern_bits      = value;
      CFG_NOTE_NUMBERS:      regs.note_numbers      = value[27:0];
      CFG_VELOCITIES:        regs.velocities        = value[27:0];
      CFG_DRUM_MASK:         regs.drum_mask         = value[3:0];
      CFG_INSTRUMENT_ENABLE: regs.instrument_enable = value[3:0];
      default: ;  // unmapped index is ignored
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_block(input logic [StartW-1:0] start, input logic [SampleW-1:0] samples);
    blocks_pending.push_back({3'b000, samples, start});
  endtask

  // Blocks that emit nothing can still be in flight: pad, then wait for the idle ready.
  task automatic settle();
    while (blocks_pending.size() != 0 || s_axis_tvalid || events_due.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [31:0]        sps;
    logic [15:0]        nlen;
    logic [63:0]        pat;
    logic [27:0]        notes, vels;
    logic [3:0]         drum, en;
    logic [StartW-1:0]  start;
    logic [SampleW-1:0] samples;
    int unsigned        mode, r;

    regs.samples_per_step  = RstSamplesPerStep;
    regs.note_length       = RstNoteLength;
    regs.pattern_bits      = '0;
    regs.note_numbers      = RstNoteNumbers;
    regs.velocities        = RstVelocities;
    regs.drum_mask         = '0;
    regs.instrument_enable = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: nothing enabled, so no events
    queue_block(40'h0, 13'd4096);
    queue_block(40'hFFFFFFFFFF, 13'd100);
    settle();

    // 1000 samples per step; steps 4..7 silent for every instrument
    write_reg(CFG_SAMPLES_PER_STEP, 64'd65536000);
    write_reg(CFG_NOTE_LENGTH, 64'd300);
    write_reg(CFG_PATTERN_BITS, {16'h0001, 16'h5505, 16'hAA0A, 16'hFF0F});
    write_reg(CFG_NOTE_NUMBERS, {$urandom, $urandom});
    write_reg(CFG_VELOCITIES, {36'd0, 14'($urandom), 7'd127, 7'd0});
    write_reg(CFG_DRUM_MASK, 64'b0101);
    write_reg(CFG_INSTRUMENT_ENABLE, 64'hF);
    queue_block(40'h0, 13'd4096);
    queue_block(40'hFFFFFFFFFF, 13'd4096);    // just before a step
    queue_block(40'h7FFFFFFFFF, 13'd4096);
    queue_block(40'h8000000000, 13'd4096);
    queue_block(40'h0, 13'd0);                // empty block
    queue_block(40'h0, 13'd1);                // everything clamps to offset 0
    queue_block(40'h50000, 13'd8191);         // oversized, saturates
    queue_block(40'h20000, 13'd4097);
    queue_block(40'h30001, 13'd4096);         // distance just under one step
    queue_block(40'hF0000, 13'd2000);         // step index wraps 15 -> 0
    queue_block(40'hFFFFFE0000, 13'd3000);
    queue_block(40'h0, 13'd1000);             // second step lands exactly on the end
    queue_block(40'h0, 13'd1001);
    queue_block(40'h60000, 13'd4096);         // two silent steps
    queue_block(40'h70000, 13'd4096);         // silent step still uses a slot
    settle();

    // zero step size and the longest note
    write_reg(CFG_SAMPLES_PER_STEP, 64'd0);
    write_reg(CFG_NOTE_LENGTH, 64'd65535);
    write_reg(CFG_PATTERN_BITS, {$urandom, $urandom});
    write_reg(CFG_DRUM_MASK, 64'b1000);
    write_reg(CFG_INSTRUMENT_ENABLE, 64'b1010);
    queue_block(40'($urandom), 13'd4096);
    queue_block(40'h0, 13'd1);
    queue_block({$urandom, 8'($urandom)}, 13'd2500);
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      mode = p * 3 / NumPhases;
      sps   = $urandom_range(65536, 65536 * 2500);
      nlen  = 16'($urandom_range(1, 3000));
      pat   = {$urandom, $urandom};
      notes = 28'($urandom);
      vels  = 28'($urandom);
      drum  = 4'($urandom);
      en    = 4'($urandom_range(1, 15));
      if (p == 0) begin
        sps = 32'd65536; nlen = 16'd1; pat = '1; vels = '0; drum = 4'hF; en = 4'hF;
      end else if (p == 1) begin
        sps = '1; nlen = '1; notes = '1; vels = '1; drum = 4'h0; en = 4'hF;
      end else if (p == 2) begin
        write_reg(CfgIdxUnmapped, {$urandom, $urandom});
      end
      write_reg(CFG_SAMPLES_PER_STEP, {$urandom, sps});
      write_reg(CFG_NOTE_LENGTH, {$urandom, 16'($urandom), nlen});
      write_reg(CFG_PATTERN_BITS, pat);
      write_reg(CFG_NOTE_NUMBERS, {$urandom, 4'($urandom), notes});
      write_reg(CFG_VELOCITIES, {$urandom, 4'($urandom), vels});
      write_reg(CFG_DRUM_MASK, {$urandom, 28'($urandom), drum});
      write_reg(CFG_INSTRUMENT_ENABLE, {$urandom, 28'($urandom), en});
      tx_idle_pct = TxIdle[mode];
      rx_idle_pct = RxIdle[mode];
      for (int k = 0; k < PhaseItems; k++) begin
        start = 40'({$urandom, $urandom});
        case ($urandom_range(3))
          0: start[15:0] = 16'h0;
          1: start[15:0] = 16'hFFFF - 16'($urandom_range(0, 255));
          default: ;
        endcase
        r = $urandom_range(99);
        if (r < 8)       samples = 13'd0;
        else if (r < 16) samples = 13'($urandom_range(4097, 8191));
        else if (r < 40) samples = 13'($urandom_range(1, 64));
        else             samples = 13'($urandom_range(65, 4096));
        queue_block(start, samples);
      end
      settle();
    end

    if (mismatches == 0 && events_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sns_pkg.sv
rtl/core/sns_cfg.sv
rtl/core/sns_mul.sv
rtl/core/sns_out.sv
rtl/core/sns_ctrl.sv
rtl/core/step_sequencer_note_scheduler.sv
dv/tb_top.sv
